// ----- src/dbpf_pkg.sv -----
package dbpf_pkg;

  // default sizes
  localparam int CHANNELS_DEF = 6;
  localparam int FILTERS_DEF  = 16;
  localparam int MAX_TAPS_DEF = 128;

  // fixed field widths
  localparam int CMD_W     = 3;
  localparam int CH_IN_W   = 3;
  localparam int FILT_IN_W = 4;
  localparam int TAP_IN_W  = 7;
  localparam int COEF_W    = 9;
  localparam int ORDER_W   = 8;
  localparam int PRED_W    = 16;
  localparam int HIST_W    = 128;

  // coefficients read per cycle
  localparam int LANES  = 8;
  localparam int LANE_W = 3;

  localparam logic [HIST_W-1:0] HIST_RESET = {(HIST_W / 8){8'haa}};

  typedef enum logic [CMD_W-1:0] {
    CMD_PEEK     = 3'd0,
    CMD_DECODE   = 3'd1,
    CMD_WR_COEF  = 3'd2,
    CMD_WR_ORDER = 3'd3,
    CMD_RST_HIST = 3'd4
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic rd_en;
    logic load_out;
  } dbpf_ctl_t;

  typedef struct packed {
    logic run_req;
    logic last_row;
    logic out_free;
  } dbpf_sts_t;

endpackage

// ----- src/dbpf_ctrl.sv -----
module dbpf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  dbpf_pkg::dbpf_sts_t sts,
  output logic                in_stall,
  output dbpf_pkg::dbpf_ctl_t ctl
);
  import dbpf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  always_comb begin
    accept       = in_valid && (state_r == ST_IDLE);
    in_stall     = (state_r != ST_IDLE);
    ctl.accept   = accept;
    ctl.start    = accept && sts.run_req;
    ctl.rd_en    = (state_r == ST_RUN);
    ctl.load_out = (state_r == ST_DONE) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && sts.run_req) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (sts.last_row) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/dbpf_datapath.sv -----
module dbpf_datapath #(
  parameter int CHANNELS = dbpf_pkg::CHANNELS_DEF,
  parameter int FILTERS  = dbpf_pkg::FILTERS_DEF,
  parameter int MAX_TAPS = dbpf_pkg::MAX_TAPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic        [dbpf_pkg::CMD_W-1:0]     in_command,
  input  logic        [dbpf_pkg::CH_IN_W-1:0]   in_channel,
  input  logic        [dbpf_pkg::FILT_IN_W-1:0] in_filter_index,
  input  logic        [dbpf_pkg::TAP_IN_W-1:0]  in_tap,
  input  logic signed [dbpf_pkg::COEF_W-1:0]    in_coef_value,
  input  logic        [dbpf_pkg::ORDER_W-1:0]   in_filter_order,
  input  logic                                  in_residual,
  input  dbpf_pkg::dbpf_ctl_t                   ctl,
  output dbpf_pkg::dbpf_sts_t                   sts,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic signed [dbpf_pkg::PRED_W-1:0]    out_prediction,
  output logic                                  out_decoded_bit
);
  import dbpf_pkg::*;

  localparam int ROWS      = (MAX_TAPS + LANES - 1) / LANES;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FILT_W    = (FILTERS > 1) ? $clog2(FILTERS) : 1;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WORK_W    = ROWS * LANES;
  localparam int ADDR_W    = FILT_W + ROW_W;
  localparam int MEM_DEPTH = FILTERS * (1 << ROW_W);

  // input decode
  cmd_t             cmd;
  logic             is_run_cmd;
  logic             ch_ok, f_ok, tap_ok;
  logic [4:0]       ch_ext;
  logic [CH_W-1:0]  ch_idx;
  logic [FILT_W-1:0] f_idx;
  logic [3:0]       tap_row;
  logic [LANE_W-1:0] wr_lane;
  logic [ADDR_W-1:0] wr_addr;
  logic             coef_we;
  logic [ORDER_W-1:0] ord_sel, ord_sat;

  // state
  logic [HIST_W-1:0]  hist_r  [CHANNELS];
  logic [ORDER_W-1:0] order_r [FILTERS];

  // item context
  logic [CH_W-1:0]    ctx_ch_r;
  logic [FILT_W-1:0]  ctx_f_r;
  logic               ctx_dec_r;
  logic               ctx_res_r;
  logic [ORDER_W-1:0] ord_sat_r;
  logic [WORK_W-1:0]  work_r;
  logic [ROW_W-1:0]   row_r;
  logic [ORDER_W-1:0] tap_base_r;
  logic               dv_r;
  logic [PRED_W-1:0]  acc_r;
  logic [PRED_W-1:0]  sum;
  logic [ORDER_W:0]   tap_idx;
  logic [PRED_W-1:0]  term;
  logic               dec_bit;

  logic [ADDR_W-1:0]             rd_addr;
  logic [LANES-1:0][COEF_W-1:0]  rd_data;

  logic               out_valid_r;
  logic [PRED_W-1:0]  out_pred_r;
  logic               out_bit_r;

  assign cmd = cmd_t'(in_command);

  always_comb begin
    case (cmd)
      CMD_PEEK:   is_run_cmd = 1'b1;
      CMD_DECODE: is_run_cmd = 1'b1;
      default:    is_run_cmd = 1'b0;
    endcase
  end

  assign ch_ext  = {2'b00, in_channel};
  assign ch_ok   = (ch_ext < 5'(CHANNELS));
  assign f_ok    = ({1'b0, in_filter_index} < 5'(FILTERS));
  assign tap_ok  = ({1'b0, in_tap} < 8'(MAX_TAPS));
  assign ch_idx  = ch_ext[CH_W-1:0];
  assign f_idx   = in_filter_index[FILT_W-1:0];
  assign tap_row = in_tap[TAP_IN_W-1:LANE_W];
  assign wr_lane = in_tap[LANE_W-1:0];
  assign wr_addr = {f_idx, tap_row[ROW_W-1:0]};
  assign coef_we = ctl.accept && (cmd == CMD_WR_COEF) && f_ok && tap_ok;

  // order above the tap count is kept as written, clipped on use
  assign ord_sel = order_r[f_idx];
  assign ord_sat = (ord_sel > ORDER_W'(MAX_TAPS)) ? ORDER_W'(MAX_TAPS) : ord_sel;

  assign sts.run_req  = is_run_cmd && ch_ok && f_ok;
  assign sts.last_row = (row_r == ROW_W'(ROWS - 1));
  assign sts.out_free = !out_valid_r || !out_stall;

  // coefficient lanes: lane i holds taps with tap mod 8 == i
  assign rd_addr = {ctx_f_r, row_r};

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [COEF_W-1:0] mem [MEM_DEPTH];
    logic [COEF_W-1:0] rd_q;

    always_ff @(posedge clk) begin
      if (coef_we && (wr_lane == LANE_W'(i))) begin
        mem[wr_addr] <= in_coef_value;
      end
      if (ctl.rd_en) begin
        rd_q <= mem[rd_addr];
      end
    end

    assign rd_data[i] = rd_q;
  end

  // one row of eight signed taps per cycle
  always_comb begin
    sum = acc_r;
    tap_idx = '0;
    term = '0;
    for (int i = 0; i < LANES; i++) begin
      tap_idx = {1'b0, tap_base_r} + (ORDER_W + 1)'(i);
      term = {{(PRED_W - COEF_W){rd_data[i][COEF_W-1]}}, rd_data[i]};
      if (tap_idx < {1'b0, ord_sat_r}) begin
        if (work_r[i]) begin
          sum = sum + term;
        end else begin
          sum = sum - term;
        end
      end
    end
  end

  assign dec_bit = acc_r[PRED_W-1] ^ ctx_res_r;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      ctx_ch_r   <= ch_idx;
      ctx_f_r    <= f_idx;
      ctx_dec_r  <= (cmd == CMD_DECODE);
      ctx_res_r  <= in_residual;
      ord_sat_r  <= ord_sat;
      work_r     <= hist_r[ch_idx][WORK_W-1:0];
      row_r      <= '0;
      tap_base_r <= '0;
      acc_r      <= '0;
    end else begin
      if (ctl.rd_en) begin
        row_r <= row_r + ROW_W'(1);
      end
      if (dv_r) begin
        acc_r      <= sum;
        work_r     <= work_r >> LANES;
        tap_base_r <= tap_base_r + ORDER_W'(LANES);
      end
    end
    if (ctl.load_out) begin
      out_pred_r <= acc_r;
      out_bit_r  <= ctx_dec_r ? dec_bit : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        hist_r[c] <= HIST_RESET;
      end
      for (int f = 0; f < FILTERS; f++) begin
        order_r[f] <= '0;
      end
    end else begin
      dv_r <= ctl.rd_en;
      if (ctl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ctl.accept && (cmd == CMD_WR_ORDER) && f_ok) begin
        order_r[f_idx] <= in_filter_order;
      end
      if (ctl.accept && (cmd == CMD_RST_HIST)) begin
        for (int c = 0; c < CHANNELS; c++) begin
          hist_r[c] <= HIST_RESET;
        end
      end else if (ctl.load_out && ctx_dec_r) begin
        hist_r[ctx_ch_r] <= {hist_r[ctx_ch_r][HIST_W-2:0], dec_bit};
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_prediction  = out_pred_r;
  assign out_decoded_bit = out_bit_r;

endmodule

// ----- src/dst_bit_prediction_filter.sv -----
// channel   | direction | handshake         | payload
// in_       | input     | in_valid/in_stall | command, channel, filter_index, tap,
//           |           |                   | coef_value, filter_order, residual
// out_      | output    | out_valid/out_stall | prediction, decoded_bit
//
// peek and decode items read ceil(MAX_TAPS/8) coefficient rows, with their pace set by
// the coefficient lanes delivering one row of eight taps per cycle
// coefficient, order and history-reset items complete in the accept cycle
// rst_n is synchronous, active low; histories come up as 0xaa per byte, orders zero,
// coefficients hold nothing defined until written
// a finished result sits in the output register while the next item is accepted;
// a stalled output only holds the block at the end of the following filter run
module dst_bit_prediction_filter #(
  parameter int CHANNELS = dbpf_pkg::CHANNELS_DEF,
  parameter int FILTERS  = dbpf_pkg::FILTERS_DEF,
  parameter int MAX_TAPS = dbpf_pkg::MAX_TAPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic        [dbpf_pkg::CMD_W-1:0]     in_command,
  input  logic        [dbpf_pkg::CH_IN_W-1:0]   in_channel,
  input  logic        [dbpf_pkg::FILT_IN_W-1:0] in_filter_index,
  input  logic        [dbpf_pkg::TAP_IN_W-1:0]  in_tap,
  input  logic signed [dbpf_pkg::COEF_W-1:0]    in_coef_value,
  input  logic        [dbpf_pkg::ORDER_W-1:0]   in_filter_order,
  input  logic                                  in_residual,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [dbpf_pkg::PRED_W-1:0]    out_prediction,
  output logic                                  out_decoded_bit
);
  import dbpf_pkg::*;

  // commands from the controller, status back from the datapath
  dbpf_ctl_t ctl;
  dbpf_sts_t sts;

  // sequencer: idle, row reads, last accumulate, result hand-off
  dbpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  // histories, orders, coefficient lanes, accumulator and output register
  dbpf_datapath #(
    .CHANNELS (CHANNELS),
    .FILTERS  (FILTERS),
    .MAX_TAPS (MAX_TAPS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_command),
    .in_channel      (in_channel),
    .in_filter_index (in_filter_index),
    .in_tap          (in_tap),
    .in_coef_value   (in_coef_value),
    .in_filter_order (in_filter_order),
    .in_residual     (in_residual),
    .ctl             (ctl),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_prediction  (out_prediction),
    .out_decoded_bit (out_decoded_bit)
  );

endmodule

// ----- src/dbpf_checker.sv -----
module dbpf_checker #(
  parameter int CHANNELS = dbpf_pkg::CHANNELS_DEF,
  parameter int FILTERS  = dbpf_pkg::FILTERS_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [dbpf_pkg::CMD_W-1:0]         in_command,
  input logic [dbpf_pkg::CH_IN_W-1:0]       in_channel,
  input logic [dbpf_pkg::FILT_IN_W-1:0]     in_filter_index,
  input logic                               out_valid,
  input logic                               out_stall
);
  import dbpf_pkg::*;

  logic acc_item;
  logic run_item;
  logic write_item;

  assign acc_item   = in_valid && !in_stall;
  assign run_item   = acc_item
                      && (in_command == CMD_PEEK || in_command == CMD_DECODE)
                      && ({2'b00, in_channel} < 5'(CHANNELS))
                      && ({1'b0, in_filter_index} < 5'(FILTERS));
  assign write_item = acc_item
                      && (in_command == CMD_WR_COEF || in_command == CMD_WR_ORDER
                          || in_command == CMD_RST_HIST);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("block not quiet after reset");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    run_item |=> in_stall)
    else $error("filter run did not hold off input");

  a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
    write_item |=> !in_stall)
    else $error("write item left block busy");

  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a filter run");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

endmodule

bind dst_bit_prediction_filter dbpf_checker #(
  .CHANNELS (CHANNELS),
  .FILTERS  (FILTERS)
) u_dbpf_checker (.*);
